FILE: rtl/dbei_pkg.sv
// Shared types, constants and fixed-point helpers of the biexponential integrator.
`default_nettype none
package dbei_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int ADDR_W = $clog2(NODE_COUNT);
   localparam int IDX_W = 10;
   localparam int DATA_W = 32;
   localparam int PADDR_W = 5;
   localparam int NUM_STAGES = 12;

   localparam logic [2:0] REG_RATE_ALPHA = 3'd0;
   localparam logic [2:0] REG_RATE_BETA = 3'd1;
   localparam logic [2:0] REG_STEP_LENGTH = 3'd2;
   localparam logic [2:0] REG_INV_STEP = 3'd3;
   localparam logic [2:0] REG_DECAY_ALPHA = 3'd4;
   localparam logic [2:0] REG_DECAY_BETA = 3'd5;
   localparam logic [2:0] REG_SUM_INV_RATES = 3'd6;
   localparam logic [2:0] REG_INV_RATE_DIFF = 3'd7;

   typedef struct packed {
      logic [30:0] rate_alpha;
      logic [30:0] rate_beta;
      logic [31:0] step_length;
      logic [30:0] inv_step_length;
      logic [31:0] decay_factor_alpha;
      logic [31:0] decay_factor_beta;
      logic [31:0] sum_inverse_rates;
      logic signed [31:0] inv_rate_difference;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic [IDX_W-1:0] idx;
      logic ok;
      logic signed [31:0] pd;
      logic signed [31:0] v;
      logic signed [31:0] d;
      logic signed [31:0] old;
      logic signed [31:0] diff;
      logic signed [31:0] dpdt;
      logic signed [31:0] fab;
      logic signed [31:0] adj;
      logic signed [31:0] mb;
      logic signed [31:0] ma;
      logic signed [31:0] num;
      logic signed [31:0] c1e;
      logic signed [31:0] c1;
      logic signed [31:0] mfs;
      logic signed [31:0] c1ea;
      logic signed [31:0] t;
      logic signed [31:0] c12;
      logic signed [31:0] c2eb;
      logic signed [31:0] mf;
      logic signed [31:0] mq;
      logic signed [31:0] ma2;
      logic signed [31:0] mb2;
      logic signed [31:0] newv;
      logic signed [31:0] inner;
      logic signed [31:0] mi;
      logic signed [31:0] newd;
   } work_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (x < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [65:0] sx(input logic signed [31:0] x);
      return 66'(x);
   endfunction

   // Q16.16 times a non-negative Q16.16 rate, rounded toward minus infinity.
   function automatic logic signed [31:0] mul_q16(input logic signed [31:0] a,
                                                  input logic [30:0] b);
      logic signed [63:0] p;
      logic signed [63:0] s;
      p = a * $signed({1'b0, b});
      s = p >>> 16;
      return sat32(66'(s));
   endfunction

   // Q16.16 times an unsigned Q0.32 fraction.
   function automatic logic signed [31:0] mul_frac(input logic signed [31:0] a,
                                                   input logic [31:0] f);
      logic signed [64:0] p;
      logic signed [64:0] s;
      p = a * $signed({1'b0, f});
      s = p >>> 32;
      return sat32(66'(s));
   endfunction

   // Q16.16 times a signed Q8.24 value.
   function automatic logic signed [31:0] mul_q24(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] s;
      p = a * b;
      s = p >>> 24;
      return sat32(66'(s));
   endfunction

endpackage
`default_nettype wire

FILE: rtl/dbei_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module dbei_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/dbei_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module dbei_csr import dbei_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [PADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);
   cfg_type cfg_ff;
   logic [2:0] sel;
   logic wr;

   assign sel = csr_paddr[PADDR_W-1:2];
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_alpha <= 31'd2949120;
         cfg_ff.rate_beta <= 31'd12124160;
         cfg_ff.step_length <= 32'd429497;
         cfg_ff.inv_step_length <= 31'd655360000;
         cfg_ff.decay_factor_alpha <= 32'd4275683394;
         cfg_ff.decay_factor_beta <= 32'd4216240850;
         cfg_ff.sum_inverse_rates <= 32'd118659767;
         cfg_ff.inv_rate_difference <= -32'sd119837;
      end else if (wr) begin
         case (sel)
            REG_RATE_ALPHA: cfg_ff.rate_alpha <= csr_pwdata[30:0];
            REG_RATE_BETA: cfg_ff.rate_beta <= csr_pwdata[30:0];
            REG_STEP_LENGTH: cfg_ff.step_length <= csr_pwdata;
            REG_INV_STEP: cfg_ff.inv_step_length <= csr_pwdata[30:0];
            REG_DECAY_ALPHA: cfg_ff.decay_factor_alpha <= csr_pwdata;
            REG_DECAY_BETA: cfg_ff.decay_factor_beta <= csr_pwdata;
            REG_SUM_INV_RATES: cfg_ff.sum_inverse_rates <= csr_pwdata;
            REG_INV_RATE_DIFF: cfg_ff.inv_rate_difference <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_RATE_ALPHA: csr_prdata = {1'b0, cfg_ff.rate_alpha};
         REG_RATE_BETA: csr_prdata = {1'b0, cfg_ff.rate_beta};
         REG_STEP_LENGTH: csr_prdata = cfg_ff.step_length;
         REG_INV_STEP: csr_prdata = {1'b0, cfg_ff.inv_step_length};
         REG_DECAY_ALPHA: csr_prdata = cfg_ff.decay_factor_alpha;
         REG_DECAY_BETA: csr_prdata = cfg_ff.decay_factor_beta;
         REG_SUM_INV_RATES: csr_prdata = cfg_ff.sum_inverse_rates;
         REG_INV_RATE_DIFF: csr_prdata = cfg_ff.inv_rate_difference;
         default: csr_prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/dbei_datapath.sv
// Twelve-stage arithmetic pipeline of the exact integration step.
`default_nettype none
module dbei_datapath import dbei_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire cfg_type          cfg,
   input  wire work_type         head,
   input  wire logic [IDX_W-1:0] probe_idx,
   output logic                  probe_hit,
   output work_type              tail
);
   work_type pipe_ff [1:NUM_STAGES];
   work_type pipe_in [1:NUM_STAGES];
   logic eq_rates;

   assign eq_rates = (cfg.rate_alpha == cfg.rate_beta);
   assign tail = pipe_ff[NUM_STAGES];

   always_comb begin
      pipe_in[1] = head;
      pipe_in[1].diff = sat32(sx(head.pd) - sx(head.old));

      pipe_in[2] = pipe_ff[1];
      pipe_in[2].dpdt = mul_q16(pipe_ff[1].diff, cfg.inv_step_length);

      pipe_in[3] = pipe_ff[2];
      pipe_in[3].fab = mul_frac(pipe_ff[2].dpdt, cfg.sum_inverse_rates);

      pipe_in[4] = pipe_ff[3];
      pipe_in[4].adj = sat32(sx(pipe_ff[3].old) - sx(pipe_ff[3].fab) - sx(pipe_ff[3].v));

      pipe_in[5] = pipe_ff[4];
      pipe_in[5].mb = mul_q16(pipe_ff[4].adj, cfg.rate_beta);
      pipe_in[5].ma = mul_q16(pipe_ff[4].adj, cfg.rate_alpha);

      pipe_in[6] = pipe_ff[5];
      pipe_in[6].num = sat32(sx(pipe_ff[5].mb) - sx(pipe_ff[5].d) + sx(pipe_ff[5].dpdt));
      pipe_in[6].c1e = sat32(sx(pipe_ff[5].d) - sx(pipe_ff[5].ma) - sx(pipe_ff[5].dpdt));

      pipe_in[7] = pipe_ff[6];
      pipe_in[7].c1 = mul_q24(pipe_ff[6].num, cfg.inv_rate_difference);
      pipe_in[7].mfs = mul_frac(pipe_ff[6].c1e, cfg.step_length);

      pipe_in[8] = pipe_ff[7];
      pipe_in[8].c1ea = mul_frac(pipe_ff[7].c1, cfg.decay_factor_alpha);
      pipe_in[8].t = sat32(-sx(pipe_ff[7].c1) - sx(pipe_ff[7].adj));
      pipe_in[8].c12 = sat32(sx(pipe_ff[7].mfs) - sx(pipe_ff[7].adj));

      pipe_in[9] = pipe_ff[8];
      pipe_in[9].c2eb = mul_frac(pipe_ff[8].t, cfg.decay_factor_beta);
      pipe_in[9].mf = mul_frac(pipe_ff[8].c12, cfg.decay_factor_alpha);
      pipe_in[9].mq = mul_q16(pipe_ff[8].c12, cfg.rate_alpha);

      pipe_in[10] = pipe_ff[9];
      pipe_in[10].ma2 = mul_q16(pipe_ff[9].c1ea, cfg.rate_alpha);
      pipe_in[10].mb2 = mul_q16(pipe_ff[9].c2eb, cfg.rate_beta);
      if (eq_rates) begin
         pipe_in[10].newv = sat32(sx(pipe_ff[9].mf) + sx(pipe_ff[9].pd) - sx(pipe_ff[9].fab));
      end else begin
         pipe_in[10].newv = sat32(sx(pipe_ff[9].c1ea) + sx(pipe_ff[9].c2eb)
                                  + sx(pipe_ff[9].pd) - sx(pipe_ff[9].fab));
      end
      pipe_in[10].inner = sat32(sx(pipe_ff[9].c1e) - sx(pipe_ff[9].mq));

      pipe_in[11] = pipe_ff[10];
      pipe_in[11].newd = sat32(-sx(pipe_ff[10].ma2) - sx(pipe_ff[10].mb2)
                               + sx(pipe_ff[10].dpdt));
      pipe_in[11].mi = mul_frac(pipe_ff[10].inner, cfg.decay_factor_alpha);

      pipe_in[12] = pipe_ff[11];
      if (eq_rates) begin
         pipe_in[12].newd = sat32(sx(pipe_ff[11].mi) + sx(pipe_ff[11].dpdt));
      end
      // A node index past the node count gives a zero result.
      if (!pipe_ff[11].ok) begin
         pipe_in[12].newv = '0;
         pipe_in[12].newd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // Any in-flight item for the same node has not yet written its state back.
   always_comb begin
      probe_hit = head.valid && (head.idx == probe_idx);
      for (int k = 1; k <= NUM_STAGES; k++) begin
         if (pipe_ff[k].valid && (pipe_ff[k].idx == probe_idx)) begin
            probe_hit = 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/dendrite_biexp_exact_integrator_unit.sv
// Top level of the dendritic biexponential exact integrator.
//
//  Channel | Direction | Ports                                   | Handshake
//  req     | in        | req_node_index, req_pulse_density       | req_valid / req_stall
//  rsp     | out       | rsp_potential, rsp_potential_slope      | rsp_valid / rsp_stall
//  csr     | in/out    | csr_paddr, csr_pwdata, csr_prdata       | APB, csr_pready always high
//
// One word per cycle for distinct nodes while rsp is not stalled; a word taken at req
// passes one memory read stage and twelve arithmetic stages before it shows at rsp.
// A word for a node that is still in the pipeline waits at req until that node's
// state is written back, which happens when its result word is taken at rsp.
// After reset the node state memory is cleared one entry a cycle, all 1024 entries, with
// req stalled. A stall at rsp while a word is shown freezes the whole pipeline and the memory read stage.
`default_nettype none
module dendrite_biexp_exact_integrator_unit import dbei_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [IDX_W-1:0]   req_node_index,
   input  wire logic signed [31:0] req_pulse_density,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_potential,
   output logic signed [31:0]      rsp_potential_slope,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [PADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   cfg_type cfg;
   work_type head;
   work_type tail;
   logic en;
   logic hit;
   logic take;
   logic rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic rd_ok_ff;
   logic signed [31:0] rd_pd_ff;
   logic clr_active_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [3*DATA_W-1:0] ram_rd;
   logic ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [3*DATA_W-1:0] ram_wd;
   logic wb;

   dbei_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready), .cfg(cfg)
   );

   assign en = !(tail.valid && rsp_stall);
   assign req_stall = clr_active_ff || hit || !en;
   assign take = req_valid && !req_stall;
   assign wb = tail.valid && !rsp_stall && tail.ok;

   always_comb begin
      ram_we = wb;
      ram_wa = tail.idx[ADDR_W-1:0];
      ram_wd = {tail.newv, tail.newd, tail.pd};
      if (clr_active_ff) begin
         ram_we = 1'b1;
         ram_wa = clr_addr_ff;
         ram_wd = '0;
      end
   end

   dbei_ram #(.WIDTH(3*DATA_W), .DEPTH(NODE_COUNT)) u_state_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_en(en), .rd_addr(req_node_index[ADDR_W-1:0]), .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(NODE_COUNT - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         if (en) begin
            rd_valid_ff <= take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_idx_ff <= req_node_index;
         rd_pd_ff <= req_pulse_density;
         rd_ok_ff <= (32'(req_node_index) < NODE_COUNT);
      end
   end

   always_comb begin
      head = '0;
      head.valid = rd_valid_ff;
      head.idx = rd_idx_ff;
      head.ok = rd_ok_ff;
      head.pd = rd_pd_ff;
      head.v = ram_rd[3*DATA_W-1:2*DATA_W];
      head.d = ram_rd[2*DATA_W-1:DATA_W];
      head.old = ram_rd[DATA_W-1:0];
   end

   dbei_datapath u_datapath (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg), .head(head),
      .probe_idx(req_node_index), .probe_hit(hit), .tail(tail)
   );

   assign rsp_valid = tail.valid;
   assign rsp_potential = tail.newv;
   assign rsp_potential_slope = tail.newd;
endmodule
`default_nettype wire

FILE: rtl/dbei_checker.sv
// Port-level checks of the integrator, bound to the top level.
`default_nettype none
module dbei_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_potential
);
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   a_clear_blocks_req: assert property (@(posedge clock)
      reset |=> req_stall ##1 req_stall)
      else $error("input taken while state memory is being cleared");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_potential))
      else $error("stalled result word changed");
endmodule

bind dendrite_biexp_exact_integrator_unit dbei_checker u_dbei_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_potential(rsp_potential)
);
`default_nettype wire

FILE: bench/dendrite_biexp_exact_integrator_unit_checker.sv
// Checker for the biexponential integrator: predicts each response word and compares it.
module dendrite_biexp_exact_integrator_unit_checker import dbei_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [IDX_W-1:0]   req_node_index,
   input wire logic signed [31:0] req_pulse_density,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_potential,
   input wire logic signed [31:0] rsp_potential_slope,
   input wire cfg_type            cfg,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] pot;
      logic signed [31:0] slope;
   } node_update_type;

   logic signed [31:0] pot_mem[NODE_COUNT];
   logic signed [31:0] slope_mem[NODE_COUNT];
   logic signed [31:0] prev_mem[NODE_COUNT];
   node_update_type    expected_updates[$];

   function automatic logic signed [31:0] clamp(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return 32'(x);
   endfunction

   // Arithmetic shift rounds toward minus infinity, which is what the block does.
   function automatic logic signed [31:0] scale(input longint a, input longint b,
                                                input int sh);
      longint p;
      p = a * b;
      return clamp(p >>> sh);
   endfunction

   function automatic node_update_type advance(input int idx,
                                               input logic signed [31:0] pd);
      node_update_type r;
      longint a, b, fa, fb, fs, ir, fdt;
      logic signed [31:0] v, d, old, dpdt, fab, adj, num, c1, c1ea, c2eb, c12, inner;
      a = longint'(cfg.rate_alpha);
      b = longint'(cfg.rate_beta);
      fa = longint'({32'd0, cfg.decay_factor_alpha});
      fb = longint'({32'd0, cfg.decay_factor_beta});
      fs = longint'({32'd0, cfg.sum_inverse_rates});
      fdt = longint'({32'd0, cfg.step_length});
      ir = longint'(cfg.inv_rate_difference);
      v = pot_mem[idx];
      d = slope_mem[idx];
      old = prev_mem[idx];
      dpdt = scale(clamp(longint'(pd) - old), longint'(cfg.inv_step_length), 16);
      fab = scale(dpdt, fs, 32);
      adj = clamp(longint'(old) - fab - v);
      if (cfg.rate_alpha != cfg.rate_beta) begin
         num = clamp(longint'(scale(adj, b, 16)) - d + dpdt);
         c1 = scale(num, ir, 24);
         c1ea = scale(c1, fa, 32);
         c2eb = scale(clamp(-longint'(c1) - adj), fb, 32);
         r.pot = clamp(longint'(c1ea) + c2eb + pd - fab);
         r.slope = clamp(-longint'(scale(c1ea, a, 16)) - longint'(scale(c2eb, b, 16))
                         + dpdt);
      end else begin
         c1 = clamp(longint'(d) - scale(adj, a, 16) - dpdt);
         c12 = clamp(longint'(scale(c1, fdt, 32)) - adj);
         r.pot = clamp(longint'(scale(c12, fa, 32)) + pd - fab);
         inner = clamp(longint'(c1) - scale(c12, a, 16));
         r.slope = clamp(longint'(scale(inner, fa, 32)) + dpdt);
      end
      pot_mem[idx] = r.pot;
      slope_mem[idx] = r.slope;
      prev_mem[idx] = pd;
      return r;
   endfunction

   assign pending_count = expected_updates.size();

   always @(posedge clock) begin
      node_update_type want;
      if (reset) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            pot_mem[i] = 0;
            slope_mem[i] = 0;
            prev_mem[i] = 0;
         end
         expected_updates.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_updates.push_back(advance(int'(req_node_index), req_pulse_density));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_updates.size() == 0) begin
               if (fail_count < 10) begin
                  $display("ERROR: unexpected word pot=%h slope=%h", rsp_potential,
                           rsp_potential_slope);
               end
               fail_count <= fail_count + 1;
            end else begin
               want = expected_updates.pop_front();
               if (want.pot !== rsp_potential || want.slope !== rsp_potential_slope) begin
                  if (fail_count < 10) begin
                     $display("ERROR: pot exp %h got %h, slope exp %h got %h", want.pot,
                              rsp_potential, want.slope, rsp_potential_slope);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: bench/dendrite_biexp_exact_integrator_unit_tb.sv
// Testbench top for the biexponential integrator: stimulus, register setup and verdict.
module dendrite_biexp_exact_integrator_unit_tb;
   import dbei_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [IDX_W-1:0]   req_node_index = '0;
   logic signed [31:0] req_pulse_density = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_potential;
   logic signed [31:0] rsp_potential_slope;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   cfg_type cfg;
   int      fail_count;
   int      pending_count;
   int      idle_cycles = 0;
   bit      hold_off = 1'b0;
   bit      long_hold = 1'b0;
   int      rsp_phase = 0;

   always #1 clock = ~clock;

   dendrite_biexp_exact_integrator_unit u_top (.*);

   dendrite_biexp_exact_integrator_unit_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_node_index, .req_pulse_density,
      .rsp_valid, .rsp_stall, .rsp_potential, .rsp_potential_slope, .cfg,
      .fail_count, .pending_count
   );

   // Register writes are mirrored for the predictor at the edge they take effect.
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= PADDR_W'({index, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_RATE_ALPHA: cfg.rate_alpha = value[30:0];
         REG_RATE_BETA: cfg.rate_beta = value[30:0];
         REG_STEP_LENGTH: cfg.step_length = value;
         REG_INV_STEP: cfg.inv_step_length = value[30:0];
         REG_DECAY_ALPHA: cfg.decay_factor_alpha = value;
         REG_DECAY_BETA: cfg.decay_factor_beta = value;
         REG_SUM_INV_RATES: cfg.sum_inverse_rates = value;
         default: cfg.inv_rate_difference = value;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_word(input logic [IDX_W-1:0] idx, input logic signed [31:0] pd);
      req_valid <= 1'b1;
      req_node_index <= idx;
      req_pulse_density <= pd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_density();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_phase(input int count, input int node_span);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_word(IDX_W'($urandom_range(0, node_span)), rand_density());
            sent++;
         end
         req_valid <= 1'b0;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      drain();
   endtask

   task automatic load_rates(input logic [31:0] ra, input logic [31:0] rb,
                             input logic [31:0] ird);
      write_reg(REG_RATE_ALPHA, ra);
      write_reg(REG_RATE_BETA, rb);
      write_reg(REG_INV_RATE_DIFF, ird);
   endtask

   // Receiver stall pattern; a long hold-off is forced on request.
   always @(negedge clock) begin
      rsp_phase <= rsp_phase + 1;
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (rsp_phase % 200 < 60) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL dendrite_biexp_exact_integrator_unit");
         $finish;
      end
   end

   initial begin
      cfg.rate_alpha = 31'd2949120;
      cfg.rate_beta = 31'd12124160;
      cfg.step_length = 32'd429497;
      cfg.inv_step_length = 31'd655360000;
      cfg.decay_factor_alpha = 32'd4275683394;
      cfg.decay_factor_beta = 32'd4216240850;
      cfg.sum_inverse_rates = 32'd118659767;
      cfg.inv_rate_difference = -32'sd119837;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: field extremes, repeated nodes and saturating inputs.
      send_word('0, 32'h00010000);
      send_word('0, 32'h00010000);
      send_word(10'd1023, 32'h7FFFFFFF);
      send_word(10'd1023, 32'h80000000);
      send_word(10'd1023, 32'h7FFFFFFF);
      send_word(10'h155, 32'h55555555);
      send_word(10'h2AA, 32'hAAAAAAAA);
      send_word(10'd7, 32'hFFFFFFFF);
      send_word(10'd7, 32'h0);
      drain();

      // Equal rates take the repeated-root path.
      load_rates(32'd2949120, 32'd2949120, 32'h7FFFFFFF);
      for (int i = 0; i < 8; i++) send_word(IDX_W'(i % 3), rand_density());
      drain();
      random_phase(150, 15);

      // Extreme register values.
      load_rates(32'h7FFFFFFF, 32'h0, 32'h80000000);
      write_reg(REG_STEP_LENGTH, 32'hFFFFFFFF);
      write_reg(REG_INV_STEP, 32'h7FFFFFFF);
      write_reg(REG_DECAY_ALPHA, 32'hFFFFFFFF);
      write_reg(REG_DECAY_BETA, 32'h0);
      write_reg(REG_SUM_INV_RATES, 32'hFFFFFFFF);
      random_phase(100, 1023);

      load_rates(32'h0, 32'h0, 32'h0);
      write_reg(REG_DECAY_ALPHA, 32'h0);
      write_reg(REG_STEP_LENGTH, 32'h0);
      random_phase(100, 1023);

      // Back to realistic values; a long receiver hold-off fills the pipeline.
      load_rates(32'd2949120, 32'd12124160, 32'hFFFE2BE3);
      write_reg(REG_STEP_LENGTH, 32'd429497);
      write_reg(REG_INV_STEP, 32'd655360000);
      write_reg(REG_DECAY_ALPHA, 32'd4275683394);
      write_reg(REG_DECAY_BETA, 32'd4216240850);
      write_reg(REG_SUM_INV_RATES, 32'd118659767);
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 60; i++) send_word(IDX_W'(i), rand_density());
      join
      drain();
      random_phase(300, 31);
      random_phase(300, 1023);

      if (fail_count == 0) begin
         $display("PASS dendrite_biexp_exact_integrator_unit");
      end else begin
         $display("FAIL dendrite_biexp_exact_integrator_unit");
      end
      $finish;
   end
endmodule
